// File: rtl/core/movr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movr_pkg
// Shared types and constants for the mask overlap maximum ratio unit.
// ----------------------------------------------------------------------------
package movr_pkg;

    // Pixel weight is unsigned Q0.16; the ratio carries 16 fraction bits
    localparam int WEIGHT_BITS     = 16;
    localparam int FRAC_BITS       = 16;
    localparam int RATIO_W         = FRAC_BITS + 1;
    localparam int FLAGS_W         = 2;
    localparam int MAX_PIXELS_DEF  = 1048576;

    // empty_flags bit positions
    localparam int FLAG_WEIGHT_EMPTY = 0;
    localparam int FLAG_MASK_EMPTY   = 1;

    typedef struct packed {
        logic                   mask_bit;
        logic [WEIGHT_BITS-1:0] predicted_weight;
        logic                   last_pixel;
    } movr_pixel_t;

    typedef struct packed {
        logic [RATIO_W-1:0] similarity;
        logic [FLAGS_W-1:0] empty_flags;
    } movr_result_t;

endpackage

// File: rtl/core/mask_overlap_max_ratio_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_overlap_max_ratio_unit
// Frame-wide overlap between a binary reference mask and a predicted weight
// map; reports the larger of weight precision and hit recall in Q1.16.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                   Handshake
//  --------  ----------------------  -----------------------------------------
//  pixel     pixel (movr_pixel_t)    transfer when start high and busy low
//  result    result (movr_result_t)  transfer on the single cycle done is high
//
//  For ordinary pixels busy stays low and a pixel may be
//  transferred every cycle. A pixel flagged last_pixel raises busy for a
//  setup state (ST_LOAD) and up to 16 restoring steps (ST_ITER) per ratio,
//  both run through the one shared compare/subtract unit. The result
//  strobe follows; busy drops in the same cycle, so the next frame may
//  start while done is high.
//  Reset clears the sums and the sequencer. The receiver cannot stall, so
//  the result is shown exactly once and nothing is held back for it.
//
module mask_overlap_max_ratio_unit
    import movr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  movr_pixel_t  pixel,
    output logic         done,
    output movr_result_t result
);

    // Count and weight-sum widths follow from the frame size cap
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam longint WEIGHT_MAX = (longint'(1) << WEIGHT_BITS) - 1;
    localparam longint SUM_CAP_L  = longint'(MAX_PIXELS) * WEIGHT_MAX;
    localparam int SUM_W  = $clog2(SUM_CAP_L + 1);
    localparam int STEP_W = $clog2(FRAC_BITS);

    localparam logic [CNT_W-1:0]   CNT_CAP  = CNT_W'(MAX_PIXELS);
    localparam logic [SUM_W-1:0]   SUM_CAP  = SUM_W'(SUM_CAP_L);
    localparam logic [STEP_W-1:0]  STEP_END = STEP_W'(FRAC_BITS - 1);
    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_ITER = 2'd2;

    // Ratio select for the shared divider
    localparam logic SEL_WEIGHT = 1'b0;
    localparam logic SEL_COUNT  = 1'b1;

    logic [1:0]         state_reg,  state_next;
    logic               sel_reg,    sel_next;
    logic [STEP_W-1:0]  step_reg,   step_next;
    logic [SUM_W-1:0]   rem_reg,    rem_next;
    logic [RATIO_W-1:0] quo_reg,    quo_next;
    logic [RATIO_W-1:0] ratio_w_reg, ratio_w_next;
    logic [FLAGS_W-1:0] flags_reg,  flags_next;

    logic [SUM_W-1:0]   wmask_reg,  wmask_next;
    logic [SUM_W-1:0]   wtotal_reg, wtotal_next;
    logic [CNT_W-1:0]   mcount_reg, mcount_next;
    logic [CNT_W-1:0]   hcount_reg, hcount_next;

    logic               done_reg,   done_next;
    movr_result_t       result_reg, result_next;

    logic               accept;
    logic [SUM_W:0]     wmask_sum;
    logic [SUM_W:0]     wtotal_sum;
    logic [SUM_W-1:0]   weight_ext;

    // Shared divider operands and datapath
    logic [SUM_W-1:0]   div_num;
    logic [SUM_W-1:0]   div_den;
    logic [SUM_W:0]     rem_shift;
    logic               rem_fits;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign result     = result_reg;

    assign weight_ext = SUM_W'(pixel.predicted_weight);
    assign wmask_sum  = {1'b0, wmask_reg}  + {1'b0, weight_ext};
    assign wtotal_sum = {1'b0, wtotal_reg} + {1'b0, weight_ext};

    assign div_num   = (sel_reg == SEL_COUNT) ? SUM_W'(hcount_reg) : wmask_reg;
    assign div_den   = (sel_reg == SEL_COUNT) ? SUM_W'(mcount_reg) : wtotal_reg;
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_fits  = (rem_shift >= {1'b0, div_den});

    always_comb
    begin
        logic               ratio_done;
        logic [RATIO_W-1:0] ratio_val;

        ratio_done   = 1'b0;
        ratio_val    = quo_reg;

        state_next   = state_reg;
        sel_next     = sel_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ratio_w_next = ratio_w_reg;
        flags_next   = flags_reg;
        wmask_next   = wmask_reg;
        wtotal_next  = wtotal_reg;
        mcount_next  = mcount_reg;
        hcount_next  = hcount_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // Saturating sums; numerators never pass their denominators
                    if (pixel.mask_bit)
                    begin
                        wmask_next = (wmask_sum >= {1'b0, SUM_CAP}) ? SUM_CAP
                                                                    : wmask_sum[SUM_W-1:0];
                        if (mcount_reg != CNT_CAP)
                            mcount_next = mcount_reg + CNT_W'(1);
                        if ((pixel.predicted_weight != '0) && (hcount_reg != CNT_CAP))
                            hcount_next = hcount_reg + CNT_W'(1);
                    end
                    wtotal_next = (wtotal_sum >= {1'b0, SUM_CAP}) ? SUM_CAP
                                                                  : wtotal_sum[SUM_W-1:0];
                    if (pixel.last_pixel)
                    begin
                        state_next = ST_LOAD;
                        sel_next   = SEL_WEIGHT;
                        flags_next = '0;
                    end
                end
            end

            ST_LOAD:
            begin
                if (div_den == '0)
                begin
                    // Empty denominator: ratio reads as zero, flag it
                    ratio_done = 1'b1;
                    ratio_val  = '0;
                    if (sel_reg == SEL_COUNT)
                        flags_next[FLAG_MASK_EMPTY] = 1'b1;
                    else
                        flags_next[FLAG_WEIGHT_EMPTY] = 1'b1;
                end
                else if (div_num >= div_den)
                begin
                    ratio_done = 1'b1;
                    ratio_val  = RATIO_ONE;
                end
                else
                begin
                    rem_next   = div_num;
                    quo_next   = '0;
                    step_next  = '0;
                    state_next = ST_ITER;
                end
            end

            ST_ITER:
            begin
                // One restoring division step per cycle
                if (rem_fits)
                    rem_next = SUM_W'(rem_shift - {1'b0, div_den});
                else
                    rem_next = rem_shift[SUM_W-1:0];
                quo_next  = {quo_reg[RATIO_W-2:0], rem_fits};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_END)
                begin
                    ratio_done = 1'b1;
                    ratio_val  = {quo_reg[RATIO_W-2:0], rem_fits};
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ratio_done)
        begin
            if (sel_reg == SEL_WEIGHT)
            begin
                ratio_w_next = ratio_val;
                sel_next     = SEL_COUNT;
                state_next   = ST_LOAD;
            end
            else
            begin
                result_next.similarity  = (ratio_w_reg > ratio_val) ? ratio_w_reg : ratio_val;
                result_next.empty_flags = flags_next;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
                wmask_next  = '0;
                wtotal_next = '0;
                mcount_next = '0;
                hcount_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sel_reg    <= SEL_WEIGHT;
            done_reg   <= 1'b0;
            wmask_reg  <= '0;
            wtotal_reg <= '0;
            mcount_reg <= '0;
            hcount_reg <= '0;
            flags_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            done_reg   <= done_next;
            wmask_reg  <= wmask_next;
            wtotal_reg <= wtotal_next;
            mcount_reg <= mcount_next;
            hcount_reg <= hcount_next;
            flags_reg  <= flags_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        ratio_w_reg <= ratio_w_next;
        result_reg  <= result_next;
    end

endmodule

// File: sim/mask_overlap_ratio_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_overlap_ratio_checker
// Watches the pixel and result channels of the overlap unit, keeps its own
// frame sums, predicts each frame's similarity and flags, and compares.
// ----------------------------------------------------------------------------
module mask_overlap_ratio_checker
    import movr_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         busy,
    input  movr_pixel_t  pixel,
    input  logic         done,
    input  movr_result_t result,
    output int           fail_count,
    output int           pending
);

    localparam logic [63:0] COUNT_CAP = 64'(MAX_PIXELS);
    localparam logic [63:0] WSUM_CAP  = 64'(MAX_PIXELS) * ((64'd1 << WEIGHT_BITS) - 64'd1);

    // predicted frame sums
    logic [63:0] acc_weight_in_mask = '0;
    logic [63:0] acc_mask_pixels    = '0;
    logic [63:0] acc_hit_pixels     = '0;
    logic [63:0] acc_weight_total   = '0;

    movr_result_t expected_frames[$];
    int           mismatches = 0;

    function automatic logic [63:0] capped_sum(input logic [63:0] acc, inc, cap);
        if (acc >= cap || inc >= cap - acc)
            return cap;
        return acc + inc;
    endfunction

    // floor(num * 2^16 / den), restoring division; num >= den saturates to 1.0
    function automatic logic [RATIO_W-1:0] ratio_q16(input logic [63:0] num, den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = num;
        if (num >= den)
            return RATIO_W'(1) << FRAC_BITS;
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo[RATIO_W-1:0];
    endfunction

    // folds one pixel in; returns the frame result when it closes the frame
    function automatic movr_result_t frame_similarity(input movr_pixel_t px);
        movr_result_t     res;
        logic [RATIO_W-1:0] by_weight;
        logic [RATIO_W-1:0] by_count;
        res       = '0;
        by_weight = '0;
        by_count  = '0;
        if (px.mask_bit)
        begin
            acc_weight_in_mask = capped_sum(acc_weight_in_mask, 64'(px.predicted_weight), WSUM_CAP);
            acc_mask_pixels    = capped_sum(acc_mask_pixels, 64'd1, COUNT_CAP);
            if (px.predicted_weight != '0)
                acc_hit_pixels = capped_sum(acc_hit_pixels, 64'd1, COUNT_CAP);
        end
        acc_weight_total = capped_sum(acc_weight_total, 64'(px.predicted_weight), WSUM_CAP);
        if (acc_weight_total == '0)
            res.empty_flags[FLAG_WEIGHT_EMPTY] = 1'b1;
        else
            by_weight = ratio_q16(acc_weight_in_mask, acc_weight_total);
        if (acc_mask_pixels == '0)
            res.empty_flags[FLAG_MASK_EMPTY] = 1'b1;
        else
            by_count = ratio_q16(acc_hit_pixels, acc_mask_pixels);
        res.similarity = (by_weight > by_count) ? by_weight : by_count;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        movr_result_t want;
        if (!rst_n)
        begin
            acc_weight_in_mask = '0;
            acc_mask_pixels    = '0;
            acc_hit_pixels     = '0;
            acc_weight_total   = '0;
            expected_frames.delete();
            pending <= 0;
        end
        else
        begin
            // result side first: a new frame may start while done is high
            if (done)
            begin
                if (expected_frames.size() == 0)
                begin
                    $display("%0t: unexpected result transfer, expected none, got sim=%0d flags=%b",
                             $time, result.similarity, result.empty_flags);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (result.similarity !== want.similarity)
                    begin
                        $display("%0t: similarity mismatch, expected %0d, got %0d",
                                 $time, want.similarity, result.similarity);
                        mismatches++;
                    end
                    if (result.empty_flags !== want.empty_flags)
                    begin
                        $display("%0t: empty_flags mismatch, expected %b, got %b",
                                 $time, want.empty_flags, result.empty_flags);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = frame_similarity(pixel);
                if (pixel.last_pixel)
                begin
                    expected_frames.push_back(want);
                    acc_weight_in_mask = '0;
                    acc_mask_pixels    = '0;
                    acc_hit_pixels     = '0;
                    acc_weight_total   = '0;
                end
            end
            pending <= expected_frames.size();
        end
        fail_count <= mismatches;
    end

endmodule

// File: sim/mask_overlap_max_ratio_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_overlap_max_ratio_unit_test
// Drives pixel frames into the overlap unit: a directed set covering the
// empty-denominator cases and the ratio extremes, then random frames with
// random gaps. A checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module mask_overlap_max_ratio_unit_test;
    import movr_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  PIXEL_TARGET = 400;
    // worst busy stretch after a last pixel, plus a little slack
    localparam int  SETTLE_CYCLES = 2 * (FRAC_BITS + 1) + 8;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    logic         busy;
    movr_pixel_t  pixel = '0;
    logic         done;
    movr_result_t result;

    int  fail_count;
    int  pending;
    int  cycle_count  = 0;
    int  pixels_sent  = 0;
    bit  gaps_on      = 1'b1;

    mask_overlap_max_ratio_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .pixel  (pixel),
        .done   (done),
        .result (result)
    );

    mask_overlap_ratio_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .pixel      (pixel),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // hard stop in case the unit hangs or drops a result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at %0t with %0d results outstanding", $time, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // One pixel transfer. An optional gap is taken first with start low, so
    // start is never lowered and raised within the same step. Returns on the
    // edge at which the unit took the pixel (busy sampled before the edge).
    task automatic send_pixel(input logic in_mask, input logic [WEIGHT_BITS-1:0] weight,
                              input logic last);
        if (gaps_on && $urandom_range(99) < 3)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        pixel <= movr_pixel_t'{mask_bit: in_mask, predicted_weight: weight, last_pixel: last};
        do
            @(posedge clk);
        while (busy);
        pixels_sent++;
    endtask

    // hold the sender off until every frame result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // zero-heavy weights, with full scale and tiny values well represented
    function automatic logic [WEIGHT_BITS-1:0] random_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return '0;
        if (pick < 35)
            return '1;
        if (pick < 45)
            return WEIGHT_BITS'($urandom_range(1, 15));
        return WEIGHT_BITS'($urandom_range(65535));
    endfunction

    // Random frame: mostly short, some medium, a few long. A tenth of frames
    // have no mask pixels, a tenth have no predicted weight at all.
    task automatic random_frame();
        int pick;
        int len;
        int flavour;
        logic in_mask;
        logic [WEIGHT_BITS-1:0] weight;
        pick = $urandom_range(99);
        if (pick < 70)
            len = $urandom_range(1, 6);
        else if (pick < 95)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 60);
        flavour = $urandom_range(9);
        for (int k = 0; k < len; k++)
        begin
            in_mask = (flavour == 0) ? 1'b0 : 1'($urandom_range(1));
            weight  = (flavour == 1) ? '0 : random_weight();
            send_pixel(in_mask, weight, k == len - 1);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed frames ---
        // single full-weight mask pixel: both ratios are exactly one
        send_pixel(1'b1, 16'hFFFF, 1'b1);
        // nothing at all: both denominators empty
        send_pixel(1'b0, 16'h0000, 1'b1);
        // mask pixel with zero weight: weight sum empty, recall zero
        send_pixel(1'b1, 16'h0000, 1'b1);
        // weight outside the mask only: mask empty, precision zero
        send_pixel(1'b0, 16'hFFFF, 1'b1);
        // smallest nonzero weight inside the mask
        send_pixel(1'b1, 16'h0001, 1'b1);
        // precision 2/3 beats recall 1/2, truncated
        send_pixel(1'b1, 16'h8000, 1'b0);
        send_pixel(1'b1, 16'h0000, 1'b0);
        send_pixel(1'b0, 16'h4000, 1'b1);
        // recall 2/3 beats a tiny precision
        send_pixel(1'b1, 16'h0001, 1'b0);
        send_pixel(1'b1, 16'h0001, 1'b0);
        send_pixel(1'b1, 16'h0000, 1'b0);
        send_pixel(1'b0, 16'hFFFF, 1'b1);
        // several pixels, all empty
        send_pixel(1'b0, 16'h0000, 1'b0);
        send_pixel(1'b0, 16'h0000, 1'b0);
        send_pixel(1'b0, 16'h0000, 1'b1);
        // full scale everywhere: recall one
        send_pixel(1'b1, 16'hFFFF, 1'b0);
        send_pixel(1'b0, 16'hFFFF, 1'b0);
        send_pixel(1'b1, 16'hFFFF, 1'b1);
        drain_results();

        // --- random frames; a stretch in the middle runs with no gaps ---
        while (pixels_sent < PIXEL_TARGET)
        begin
            gaps_on = (pixels_sent < 130) || (pixels_sent >= 260);
            random_frame();
            if ($urandom_range(99) < 4)
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
